// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the mapper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== src/zbam_pkg.sv =====
// ----------------------------------------------------------------------------
// zbam_pkg
// Types and constants shared by the zoned band address mapper modules.
// ----------------------------------------------------------------------------
package zbam_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_ZONE_COUNT    = 3'd0;
	localparam logic [2:0] REG_BANDS_PER_ZONE = 3'd1;
	localparam logic [2:0] REG_SMALLEST_BAND = 3'd2;
	localparam logic [2:0] REG_BAND_STEP     = 3'd3;
	localparam logic [2:0] REG_BLOCK_SHIFT   = 3'd4;

	// Register field widths
	localparam int ZC_W   = 6;
	localparam int BPZ_W  = 20;
	localparam int SMB_W  = 32;
	localparam int STEP_W = 28;
	localparam int SHF_W  = 5;
	localparam int CFG_DATA_W = 32;

	// Register reset values
	localparam logic [ZC_W-1:0]   RST_ZONE_COUNT = 6'd19;
	localparam logic [BPZ_W-1:0]  RST_BANDS_PER_ZONE = 20'd10220;
	localparam logic [SMB_W-1:0]  RST_SMALLEST_BAND = 32'd18874368;
	localparam logic [STEP_W-1:0] RST_BAND_STEP = 28'd1048576;
	localparam logic [SHF_W-1:0]  RST_BLOCK_SHIFT = 5'd12;

	// Internal arithmetic widths (cover up to 64 zones)
	localparam int SIZE_W = 35;   // band size
	localparam int ZLEN_W = 55;   // zone length = size * bands
	localparam int TOT_W  = 61;   // running zone end
	localparam int QUO_W  = 20;   // band within zone
	localparam int REM_W  = 55;   // divider remainder
	localparam int ZL_W   = 7;    // zone limit

	// Result field widths
	localparam int ZI_OUT_W = 5;
	localparam int BN_W     = 25;
	localparam int BB_W     = 34;
	localparam int BS_W     = 48;
	localparam int BLK_W    = 25;

	typedef struct packed {
		logic [ZC_W-1:0]   zone_count;
		logic [BPZ_W-1:0]  bands_per_zone;
		logic [SMB_W-1:0]  smallest_band_bytes;
		logic [STEP_W-1:0] band_step_bytes;
		logic [SHF_W-1:0]  block_shift;
	} cfg_t;

	typedef struct packed {
		logic                in_range;
		logic [ZI_OUT_W-1:0] zone_index;
		logic [BN_W-1:0]     band_number;
		logic [BB_W-1:0]     band_bytes;
		logic [BS_W-1:0]     band_start;
		logic [BLK_W-1:0]    block_in_band;
	} res_t;

endpackage

// ===== src/zbam_div.sv =====
// ----------------------------------------------------------------------------
// zbam_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zbam_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [zbam_pkg::REM_W-1:0]  dividend,
	input  logic [zbam_pkg::SIZE_W-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [zbam_pkg::QUO_W-1:0]  quo,
	output logic [zbam_pkg::REM_W-1:0]  rem
);
	import zbam_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic             fits;

	// Trial subtract of the shifted divisor
	assign fits = (rem_q >= dsh_q);

	// Control: count down the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(QUO_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: shift divisor down, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= REM_W'(divisor) << (QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

	`ASSERT_NEVER(a_no_restart, clk, arst_n, start && busy_q)
	`ASSERT_PROP(a_last_bit_done, clk, arst_n, (busy_q && cnt_q == '0 && !start) |=> done_q)
	`ASSERT_NEVER(a_done_idle, clk, arst_n, done_q && busy_q)

endmodule

// ===== src/zbam_core.sv =====
// ----------------------------------------------------------------------------
// zbam_core
// Zone walk sequencer: one multiply and one add/compare per zone, then, for an
// offset inside a zone, a shared divide for the band inside that zone.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zbam_core #(
	parameter int MAX_ZONES   = 32,
	parameter int OFFSET_BITS = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  zbam_pkg::cfg_t          cfg,
	input  logic                   start,
	input  logic [OFFSET_BITS-1:0] offset,
	input  logic                   res_take,
	output logic                   idle,
	output logic                   res_valid,
	output zbam_pkg::res_t          res
);
	import zbam_pkg::*;

	localparam int ZI_W  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int CMP_W = ((OFFSET_BITS > TOT_W) ? OFFSET_BITS : TOT_W) + 1;
	localparam logic [ZL_W-1:0] MAXZ = ZL_W'(MAX_ZONES);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_CMP  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t               st_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [TOT_W-1:0]     total_q;
	logic [SIZE_W-1:0]    size_q;
	logic [ZLEN_W-1:0]    zlen_q;
	logic [BN_W-1:0]      base_q;
	logic [ZI_W-1:0]      zi_q;
	res_t                 res_q;

	logic [ZL_W-1:0]      zlim;
	logic [ZLEN_W-1:0]    prod;
	logic [CMP_W-1:0]     zone_end;
	logic [CMP_W-1:0]     rel;
	logic                 hit;
	logic                 last_zone;
	logic                 div_start;
	logic                 div_busy;
	logic                 div_done;
	logic [QUO_W-1:0]     div_quo;
	logic [REM_W-1:0]     div_rem;
	logic [CMP_W-1:0]     start_ofs;

	// Clamp the zone count to the hardware limit
	assign zlim = (ZL_W'(cfg.zone_count) > MAXZ) ? MAXZ : ZL_W'(cfg.zone_count);

	// Shared multiplier and adder/comparator
	assign prod      = size_q * cfg.bands_per_zone;
	assign zone_end  = CMP_W'(total_q) + CMP_W'(zlen_q);
	assign hit       = (zone_end > CMP_W'(off_q));
	assign rel       = CMP_W'(off_q) - CMP_W'(total_q);
	assign last_zone = ((ZL_W'(zi_q) + 1'b1) == zlim);
	assign div_start = (st_q == ST_CMP) && hit;
	assign start_ofs = CMP_W'(off_q) - CMP_W'(div_rem);

	zbam_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (REM_W'(rel)),
		.divisor  (size_q),
		.busy     (div_busy),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						st_q <= (zlim == '0) ? ST_DONE : ST_MUL;
					end
				end
				ST_MUL: begin
					st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (hit) begin
						st_q <= ST_DIV;
					end else if (last_zone) begin
						st_q <= ST_DONE;
					end else begin
						st_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk datapath and result capture
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			off_q   <= offset;
			total_q <= '0;
			size_q  <= SIZE_W'(cfg.smallest_band_bytes);
			base_q  <= '0;
			zi_q    <= '0;
			res_q   <= '0;
		end
		if (st_q == ST_MUL) begin
			zlen_q <= prod;
		end
		if (st_q == ST_CMP && !hit) begin
			total_q <= TOT_W'(zone_end);
			size_q  <= size_q + SIZE_W'(cfg.band_step_bytes);
			base_q  <= base_q + BN_W'(cfg.bands_per_zone);
			zi_q    <= zi_q + 1'b1;
		end
		if (st_q == ST_DIV && div_done) begin
			res_q.in_range      <= 1'b1;
			res_q.zone_index    <= ZI_OUT_W'(zi_q);
			res_q.band_number   <= base_q + BN_W'(div_quo);
			res_q.band_bytes    <= BB_W'(size_q);
			res_q.band_start    <= BS_W'(start_ofs);
			res_q.block_in_band <= BLK_W'(div_rem >> cfg.block_shift);
		end
	end

	assign idle      = (st_q == ST_IDLE);
	assign res_valid = (st_q == ST_DONE);
	assign res       = res_q;

	`ASSERT_PROP(a_rem_below_size, clk, arst_n,
		(st_q == ST_DIV && div_done) |-> (REM_W'(size_q) > div_rem))
	`ASSERT_PROP(a_zone_in_limit, clk, arst_n,
		(st_q == ST_CMP || st_q == ST_DIV) |-> (ZL_W'(zi_q) < zlim))
	`ASSERT_PROP(a_miss_is_zero, clk, arst_n,
		(res_valid && !res_q.in_range) |-> (res_q.band_number == '0 && res_q.band_bytes == '0))
	`ASSERT_PROP(a_div_only_in_div, clk, arst_n, div_busy |-> (st_q == ST_DIV))

endmodule

// ===== src/zoned_band_address_mapper.sv =====
// ----------------------------------------------------------------------------
// zoned_band_address_mapper
// Maps a byte offset in a zoned shingled area onto zone, band and block.
// ----------------------------------------------------------------------------
// One offset is mapped at a time. The zones are walked in order through one
// multiplier and one adder/comparator, a multiply step and then a compare step
// per zone, and the band inside the holding zone comes from a divider that
// resolves one quotient bit per cycle. in_stall stays high while an offset is
// being mapped or its result waits for the output register; a finished result
// sits in the output register, so the next offset is taken while it waits.
// Configuration writes are always ready and must only be issued while no offset
// is in flight.
// ----------------------------------------------------------------------------
module zoned_band_address_mapper #(
	parameter int MAX_ZONES   = 32,
	parameter int OFFSET_BITS = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [2:0]                        cfg_index,
	input  logic [zbam_pkg::CFG_DATA_W-1:0]   cfg_data,
	// offset channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [OFFSET_BITS-1:0]            byte_offset,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              in_range,
	output logic [zbam_pkg::ZI_OUT_W-1:0]     zone_index,
	output logic [zbam_pkg::BN_W-1:0]         band_number,
	output logic [zbam_pkg::BB_W-1:0]         band_bytes,
	output logic [zbam_pkg::BS_W-1:0]         band_start,
	output logic [zbam_pkg::BLK_W-1:0]        block_in_band
);
	import zbam_pkg::*;

	cfg_t cfg_q;
	res_t out_q;
	logic out_valid_q;
	logic core_idle;
	logic core_res_valid;
	res_t core_res;
	logic res_take;
	logic in_take;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zone_count          <= RST_ZONE_COUNT;
			cfg_q.bands_per_zone      <= RST_BANDS_PER_ZONE;
			cfg_q.smallest_band_bytes <= RST_SMALLEST_BAND;
			cfg_q.band_step_bytes     <= RST_BAND_STEP;
			cfg_q.block_shift         <= RST_BLOCK_SHIFT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ZONE_COUNT:     cfg_q.zone_count          <= cfg_data[ZC_W-1:0];
				REG_BANDS_PER_ZONE: cfg_q.bands_per_zone      <= cfg_data[BPZ_W-1:0];
				REG_SMALLEST_BAND:  cfg_q.smallest_band_bytes <= cfg_data[SMB_W-1:0];
				REG_BAND_STEP:      cfg_q.band_step_bytes     <= cfg_data[STEP_W-1:0];
				REG_BLOCK_SHIFT:    cfg_q.block_shift         <= cfg_data[SHF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input handshake: take an offset only when the walker is free
	assign in_stall = !core_idle;
	assign in_take  = in_valid && !in_stall;

	zbam_core #(
		.MAX_ZONES   (MAX_ZONES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (in_take),
		.offset    (byte_offset),
		.res_take  (res_take),
		.idle      (core_idle),
		.res_valid (core_res_valid),
		.res       (core_res)
	);

	// Output register: load when empty or being drained
	assign res_take = core_res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= core_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign in_range      = out_q.in_range;
	assign zone_index    = out_q.zone_index;
	assign band_number   = out_q.band_number;
	assign band_bytes    = out_q.band_bytes;
	assign band_start    = out_q.band_start;
	assign block_in_band = out_q.block_in_band;

endmodule

// ===== dv/zoned_band_address_mapper_test.sv =====
// ----------------------------------------------------------------------------
// zoned_band_address_mapper_test
// Self-checking bench for the zoned band address mapper. Offsets go in through
// a bursty sender, results come out through a receiver that stalls on its own
// pattern, and each result is checked field by field against a predictor that
// walks the zones with its own copy of the registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module zoned_band_address_mapper_test;
	import zbam_pkg::*;

	localparam int OFF_W             = 48;
	localparam int ZONE_WALK_MAX     = 32;
	localparam int RESET_CYCLES      = 3;
	localparam int RANDOM_SETTINGS   = 6;
	localparam int ITEMS_PER_SETTING = 60;
	localparam int PRESSURE_ITEMS    = 30;
	localparam int HOLD_OFF_CYCLES   = 300;
	localparam int REPORT_LIMIT      = 10;
	// allowance for the worst mapping after the last offset
	localparam int TAIL_CYCLES       = 120;
	// longest quiet stretch of a correct run: the long hold-off plus one mapping,
	// the longest sender gap and a stall run; taken several times over
	localparam int QUIET_LIMIT       = 4000;

	// Indexes the block does not decode
	localparam logic [2:0] REG_UNUSED_LO = 3'd5;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;

	typedef enum logic [1:0] {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_ALTERNATE} sink_mode_t;

	typedef struct {
		logic [OFF_W-1:0] offset;
		res_t             map;
	} mapping_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [2:0]           cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [OFF_W-1:0]     byte_offset;
	logic                 out_valid;
	logic                 out_stall;
	logic                 in_range;
	logic [ZI_OUT_W-1:0]  zone_index;
	logic [BN_W-1:0]      band_number;
	logic [BB_W-1:0]      band_bytes;
	logic [BS_W-1:0]      band_start;
	logic [BLK_W-1:0]     block_in_band;

	// Predictor copy of the registers and expected mappings in flight
	cfg_t     map_cfg;
	mapping_t pending_maps[$];

	int  burst_left;
	bit  steady;
	bit  hold_req;
	int  quiet_cycles;
	int  mismatches = 0;
	int  leftover;
	int  offsets_sent;
	int  settings_used;
	int  hits = 0;
	int  misses = 0;

	zoned_band_address_mapper u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.byte_offset   (byte_offset),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.in_range      (in_range),
		.zone_index    (zone_index),
		.band_number   (band_number),
		.band_bytes    (band_bytes),
		.band_start    (band_start),
		.block_in_band (block_in_band)
	);

	always #5 clk = ~clk;

	// Number of zones actually walked under the current registers
	function automatic int walked_zones();
		return (map_cfg.zone_count > ZONE_WALK_MAX) ? ZONE_WALK_MAX : int'(map_cfg.zone_count);
	endfunction

	// Byte offset where zone 'upto' begins
	function automatic logic [63:0] zone_base(input int upto);
		logic [63:0] acc;
		logic [63:0] size;
		acc = '0;
		for (int z = 0; z < upto; z++) begin
			size = 64'(map_cfg.smallest_band_bytes) + 64'(z) * 64'(map_cfg.band_step_bytes);
			acc += size * 64'(map_cfg.bands_per_zone);
		end
		return acc;
	endfunction

	// Walk the zones until the running end passes the offset, then split into
	// band and block; empty zones add nothing and are passed over
	function automatic res_t map_offset(input logic [OFF_W-1:0] off);
		res_t        r;
		logic [63:0] zone_end;
		logic [63:0] size;
		logic [63:0] zone_len;
		logic [63:0] band_idx;
		logic [63:0] first;
		logic [63:0] wide;
		r = '0;
		zone_end = '0;
		for (int z = 0; z < walked_zones(); z++) begin
			size = 64'(map_cfg.smallest_band_bytes) + 64'(z) * 64'(map_cfg.band_step_bytes);
			zone_len = size * 64'(map_cfg.bands_per_zone);
			if (zone_end + zone_len > 64'(off)) begin
				band_idx = (64'(off) - zone_end) / size;
				first = zone_end + band_idx * size;
				r.in_range = 1'b1;
				r.zone_index = z[ZI_OUT_W-1:0];
				wide = 64'(map_cfg.bands_per_zone) * 64'(z) + band_idx;
				r.band_number = wide[BN_W-1:0];
				r.band_bytes = size[BB_W-1:0];
				r.band_start = first[BS_W-1:0];
				wide = (64'(off) - first) >> map_cfg.block_shift;
				r.block_in_band = wide[BLK_W-1:0];
				return r;
			end
			zone_end += zone_len;
		end
		return r;
	endfunction

	// Pick an offset: mostly inside the zoned area, some near band edges,
	// the rest anywhere in the address space
	function automatic logic [OFF_W-1:0] pick_offset();
		logic [63:0] noise;
		logic [63:0] span;
		logic [63:0] size;
		logic [63:0] spot;
		int          walk;
		int          z;
		noise = {$urandom, $urandom};
		walk = walked_zones();
		span = zone_base(walk);
		case ($urandom_range(0, 9))
			0, 1: spot = noise;
			2, 3, 4: begin
				if (walk == 0 || map_cfg.bands_per_zone == 0) begin
					spot = noise;
				end else begin
					z = $urandom_range(0, walk - 1);
					size = 64'(map_cfg.smallest_band_bytes) + 64'(z) * 64'(map_cfg.band_step_bytes);
					spot = zone_base(z) + (noise % 64'(map_cfg.bands_per_zone)) * size
						+ 64'($urandom_range(0, 2)) - 64'd1;
				end
			end
			default: spot = (span == 0) ? noise : noise % span;
		endcase
		return spot[OFF_W-1:0];
	endfunction

	// Send one offset, record its expected mapping, then idle as the burst says
	task automatic send_offset(input logic [OFF_W-1:0] off);
		int          gap;
		logic [63:0] junk;
		in_valid    <= 1'b1;
		byte_offset <= off;
		do @(posedge clk); while (in_stall);
		pending_maps.push_back('{offset: off, map: map_offset(off)});
		offsets_sent++;
		@(negedge clk);
		if (steady) begin
			// no gaps
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2:       gap = $urandom_range(41, 120);
				3, 4, 5, 6, 7: gap = $urandom_range(5, 40);
				8, 9:          gap = 0;
				default:       gap = $urandom_range(1, 4);
			endcase
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 12);
			if (gap > 0) begin
				junk = {$urandom, $urandom};
				in_valid    <= 1'b0;
				byte_offset <= junk[OFF_W-1:0];
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Write one register; for a decoded index the data bits beyond the field carry noise
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		logic [CFG_DATA_W-1:0] data;
		data = $urandom;
		case (idx)
			REG_ZONE_COUNT: begin
				data[ZC_W-1:0] = value[ZC_W-1:0];
				map_cfg.zone_count = value[ZC_W-1:0];
			end
			REG_BANDS_PER_ZONE: begin
				data[BPZ_W-1:0] = value[BPZ_W-1:0];
				map_cfg.bands_per_zone = value[BPZ_W-1:0];
			end
			REG_SMALLEST_BAND: begin
				data[SMB_W-1:0] = value[SMB_W-1:0];
				map_cfg.smallest_band_bytes = value[SMB_W-1:0];
			end
			REG_BAND_STEP: begin
				data[STEP_W-1:0] = value[STEP_W-1:0];
				map_cfg.band_step_bytes = value[STEP_W-1:0];
			end
			REG_BLOCK_SHIFT: begin
				data[SHF_W-1:0] = value[SHF_W-1:0];
				map_cfg.block_shift = value[SHF_W-1:0];
			end
			default: data = value[CFG_DATA_W-1:0];
		endcase
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [ZC_W-1:0] zones, input logic [BPZ_W-1:0] bands,
		input logic [SMB_W-1:0] smallest, input logic [STEP_W-1:0] step,
		input logic [SHF_W-1:0] shift);
		write_reg(REG_ZONE_COUNT, 64'(zones));
		write_reg(REG_BANDS_PER_ZONE, 64'(bands));
		write_reg(REG_SMALLEST_BAND, 64'(smallest));
		write_reg(REG_BAND_STEP, 64'(step));
		write_reg(REG_BLOCK_SHIFT, 64'(shift));
		settings_used++;
	endtask

	// Drop valid and wait until every mapping in flight has come back
	task automatic finish_phase();
		in_valid <= 1'b0;
		while (pending_maps.size() != 0) @(negedge clk);
	endtask

	// Zone and band edges under the reset register values
	task automatic test_reset_defaults();
		logic [63:0] size0;
		logic [63:0] end0;
		logic [63:0] area;
		size0 = 64'(map_cfg.smallest_band_bytes);
		end0  = zone_base(1);
		area  = zone_base(walked_zones());
		send_offset('0);
		send_offset(48'd1);
		send_offset(size0[OFF_W-1:0] - 48'd1);
		send_offset(size0[OFF_W-1:0]);
		send_offset(end0[OFF_W-1:0] - 48'd1);
		send_offset(end0[OFF_W-1:0]);
		send_offset(area[OFF_W-1:0] - 48'd1);
		send_offset(area[OFF_W-1:0]);
		send_offset('1);
		finish_phase();
	endtask

	// Register extremes, capped zone count, empty zones and unused indexes
	task automatic test_register_extremes();
		logic [63:0] area;
		// largest sizes everywhere: every offset falls in zone zero
		set_config(ZC_W'(ZONE_WALK_MAX), '1, '1, '1, 5'd16);
		send_offset('0);
		send_offset('1);
		finish_phase();
		// shifts of zero and 31 on a huge band
		write_reg(REG_BLOCK_SHIFT, 64'd0);
		send_offset('1);
		finish_phase();
		write_reg(REG_BLOCK_SHIFT, 64'd31);
		send_offset('1);
		finish_phase();
		// zone count above the walk limit, one-byte bands: reach the last zone
		set_config('1, '1, 32'd1, '0, '0);
		area = zone_base(walked_zones());
		send_offset(area[OFF_W-1:0] - 48'd1);
		send_offset(area[OFF_W-1:0]);
		finish_phase();
		// no zones at all
		write_reg(REG_ZONE_COUNT, 64'd0);
		send_offset('0);
		finish_phase();
		// single zone with a single one-byte band
		set_config(6'd1, 20'd1, 32'd1, '0, 5'd9);
		send_offset('0);
		send_offset(48'd1);
		finish_phase();
		// zones without bands
		set_config(6'd4, '0, 32'd4096, 28'd16, 5'd9);
		send_offset('0);
		finish_phase();
		// zero band size in every zone
		set_config(6'd4, 20'd2, '0, '0, 5'd9);
		send_offset('0);
		finish_phase();
		// only zone zero is empty, so the walk skips it
		write_reg(REG_BAND_STEP, 64'd3);
		send_offset('0);
		finish_phase();
		// writes to undecoded indexes leave the mapping alone
		write_reg(3'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), {$urandom, $urandom});
		send_offset('0);
		finish_phase();
	endtask

	// Receiver holds off long enough that the block backs up into its input
	task automatic test_output_hold_off();
		set_config(RST_ZONE_COUNT, RST_BANDS_PER_ZONE, RST_SMALLEST_BAND, RST_BAND_STEP,
			RST_BLOCK_SHIFT);
		hold_req = 1'b1;
		steady = 1'b1;
		repeat (PRESSURE_ITEMS) send_offset(pick_offset());
		steady = 1'b0;
		finish_phase();
	endtask

	// Random register settings, each with a batch of random offsets
	task automatic test_random_mapping();
		logic [ZC_W-1:0]   zones;
		logic [BPZ_W-1:0]  bands;
		logic [SMB_W-1:0]  smallest;
		logic [STEP_W-1:0] step;
		logic [SHF_W-1:0]  shift;
		for (int s = 0; s < RANDOM_SETTINGS; s++) begin
			case ($urandom_range(0, 9))
				0:       zones = ZC_W'($urandom_range(33, 63));
				1:       zones = 6'd1;
				default: zones = ZC_W'($urandom_range(2, ZONE_WALK_MAX));
			endcase
			bands = BPZ_W'($urandom_range(0, 1) ? $urandom_range(1, 64)
				: $urandom_range(1, 20'hFFFFF));
			case ($urandom_range(0, 3))
				0:       smallest = $urandom_range(1, 4096);
				1:       smallest = $urandom;
				default: smallest = $urandom_range(1 << 20, 1 << 26);
			endcase
			case ($urandom_range(0, 3))
				0:       step = '0;
				1:       step = STEP_W'($urandom_range(1, 4096));
				2:       step = STEP_W'($urandom);
				default: step = STEP_W'($urandom_range(0, 1 << 22));
			endcase
			shift = SHF_W'($urandom_range(0, 1) ? $urandom_range(9, 16) : $urandom_range(0, 31));
			set_config(zones, bands, smallest, step, shift);
			repeat (ITEMS_PER_SETTING) send_offset(pick_offset());
			finish_phase();
		end
	endtask

	// Compare one result field and report the first few mismatches
	task automatic compare_field(input string field, input logic [OFF_W-1:0] off,
		input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("offset 0x%0h: %s expected 0x%0h, got 0x%0h", off, field, want, got);
		end
	endtask

	// Check each result transaction against the oldest pending mapping
	always @(posedge clk) begin : result_check
		mapping_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_maps.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result transaction with no offset pending");
			end else begin
				want = pending_maps.pop_front();
				compare_field("in_range", want.offset, 64'(want.map.in_range),
					64'(in_range));
				compare_field("zone_index", want.offset, 64'(want.map.zone_index),
					64'(zone_index));
				compare_field("band_number", want.offset, 64'(want.map.band_number),
					64'(band_number));
				compare_field("band_bytes", want.offset, 64'(want.map.band_bytes),
					64'(band_bytes));
				compare_field("band_start", want.offset, 64'(want.map.band_start),
					64'(band_start));
				compare_field("block_in_band", want.offset, 64'(want.map.block_in_band),
					64'(block_in_band));
				if (want.map.in_range)
					hits++;
				else
					misses++;
			end
		end
	end

	// Stall the result side on a pattern that changes mode every so often
	initial begin : result_sink
		sink_mode_t mode;
		int         run_left;
		int         hold_left;
		bit         hold_taken;
		out_stall = 1'b0;
		mode = SINK_OPEN;
		run_left = 0;
		hold_left = 0;
		hold_taken = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (run_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				run_left = $urandom_range(20, 200);
			end
			run_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					SINK_OPEN:      out_stall <= 1'b0;
					SINK_LIGHT:     out_stall <= ($urandom_range(0, 3) == 0);
					SINK_HEAVY:     out_stall <= ($urandom_range(0, 3) != 0);
					SINK_ALTERNATE: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// End the run if no transaction moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		byte_offset = '0;
		map_cfg     = '{zone_count: RST_ZONE_COUNT, bands_per_zone: RST_BANDS_PER_ZONE,
			smallest_band_bytes: RST_SMALLEST_BAND, band_step_bytes: RST_BAND_STEP,
			block_shift: RST_BLOCK_SHIFT};
		burst_left    = 0;
		steady        = 1'b0;
		hold_req      = 1'b0;
		offsets_sent  = 0;
		settings_used = 1;

		// hold reset, then release it away from the rising edge
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_output_hold_off();
		test_random_mapping();

		finish_phase();
		repeat (TAIL_CYCLES) @(posedge clk);
		leftover = pending_maps.size();
		if (leftover != 0)
			$display("%0d mappings never came back", leftover);
		$display("Mapped %0d offsets under %0d register settings: %0d in range, %0d outside.",
			offsets_sent, settings_used, hits, misses);
		$display("Included register extremes, empty and capped zones, unused indexes");
		$display("and a %0d-cycle output hold-off.", HOLD_OFF_CYCLES);
		if (mismatches == 0 && leftover == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
